FILE: hw/rtl/dqsb_pkg.sv
package dqsb_pkg;

  // Q16.16 word and quaternion (index 0 = scalar, 1..3 = i, j, k)
  typedef logic signed [31:0] word_t;
  typedef word_t quat_t [4];

  // Full-precision partial product and the four terms of one component
  typedef logic signed [63:0] prod_t;
  typedef prod_t term_set_t [4];
  typedef term_set_t prod_set_t [4];

  // Saturated word plus its clamp flag
  typedef struct packed {
    logic signed [31:0] value;
    logic               ovf;
  } sat_t;

  localparam int unsigned FracBits = 16;

  // Hamilton product a*b: component c sums a[t] * b[TermB[c][t]]
  localparam logic [1:0] TermB [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  // Bit t set: term t of component c is subtracted
  localparam logic [3:0] TermNeg [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  // Same, with the right operand conjugated (vector terms flip sign)
  localparam logic [3:0] ConjNeg [4] = '{4'b0000, 4'b0101, 4'b1001, 4'b0011};

  // Sum four signed products exactly, floor-shift by FracBits, clamp to 32 bits
  function automatic sat_t sum_shift_sat(input term_set_t pr, input logic [3:0] neg);
    logic signed [65:0] acc;
    logic signed [65:0] term;
    logic [49:0]        shr;
    sat_t               r;
    acc = '0;
    for (int t = 0; t < 4; t++) begin
      term = {{2{pr[t][63]}}, pr[t]};
      if (neg[t]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    shr = acc[65:FracBits];
    if (!shr[49] && (|shr[48:31])) begin
      r.value = 32'sh7fff_ffff;
      r.ovf   = 1'b1;
    end else if (shr[49] && !(&shr[48:31])) begin
      r.value = 32'sh8000_0000;
      r.ovf   = 1'b1;
    end else begin
      r.value = shr[31:0];
      r.ovf   = 1'b0;
    end
    return r;
  endfunction

  // a - b clamped to 32 bits
  function automatic sat_t sub_sat(input word_t a, input word_t b);
    logic [32:0] d;
    sat_t        r;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      r.value = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      r.ovf   = 1'b1;
    end else begin
      r.value = d[31:0];
      r.ovf   = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/dual_quaternion_screw_builder_core.sv
// Builds the dual quaternion (q, d) with d = 0.5*(p - q*p*conj(q))*q from a rotation
// quaternion q and a point quaternion p, all signed Q16.16. Each Hamilton component
// sums four exact 32x32 products, floors by 2^16 and saturates; the difference also
// saturates, and overflow_o reports any clamp. busy is always low: an item is taken
// in every cycle that start is high, and its result appears on valid_o at the end of
// the pipeline, one result per item, in order. The pipeline is the three Hamilton
// products in series, each a row of sixteen multipliers followed by a summing
// stage, plus the subtract stage; the last summing stage is the output register.
// Results cannot be held off; the receiver must take each one in its strobe cycle.
module dual_quaternion_screw_builder_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  dqsb_pkg::word_t       rot_w_i,
  input  dqsb_pkg::word_t       rot_x_i,
  input  dqsb_pkg::word_t       rot_y_i,
  input  dqsb_pkg::word_t       rot_z_i,
  input  dqsb_pkg::word_t       point_w_i,
  input  dqsb_pkg::word_t       point_x_i,
  input  dqsb_pkg::word_t       point_y_i,
  input  dqsb_pkg::word_t       point_z_i,
  output logic                  valid_o,
  output dqsb_pkg::word_t       real_w_o,
  output dqsb_pkg::word_t       real_x_o,
  output dqsb_pkg::word_t       real_y_o,
  output dqsb_pkg::word_t       real_z_o,
  output dqsb_pkg::word_t       dual_w_o,
  output dqsb_pkg::word_t       dual_x_o,
  output dqsb_pkg::word_t       dual_y_o,
  output dqsb_pkg::word_t       dual_z_o,
  output logic                  overflow_o
);
  import dqsb_pkg::*;

  // valid bits, one per stage
  logic [7:1] vld_q, vld_d;

  // input operands
  quat_t q_in, p_in;

  // stage 1: products q*p
  prod_set_t prod1_q, prod1_d;
  quat_t     q1_q, p1_q;
  // stage 2: qp
  quat_t     qp2_q, qp2_d, q2_q, p2_q;
  logic      ovf2_q, ovf2_d;
  // stage 3: products qp*conj(q)
  prod_set_t prod3_q, prod3_d;
  quat_t     q3_q, p3_q;
  logic      ovf3_q;
  // stage 4: rotated point
  quat_t     rot4_q, rot4_d, q4_q, p4_q;
  logic      ovf4_q, ovf4_d;
  // stage 5: p - rotated point
  quat_t     diff5_q, diff5_d, q5_q;
  logic      ovf5_q, ovf5_d;
  // stage 6: products diff*q
  prod_set_t prod6_q, prod6_d;
  quat_t     q6_q;
  logic      ovf6_q;
  // stage 7: output register
  quat_t     dual7_q, dual7_d, q7_q;
  logic      ovf7_q, ovf7_d;

  sat_t      s2 [4];
  sat_t      s4 [4];
  sat_t      s5 [4];
  sat_t      s7 [4];

  assign busy = 1'b0;

  assign q_in = '{rot_w_i, rot_x_i, rot_y_i, rot_z_i};
  assign p_in = '{point_w_i, point_x_i, point_y_i, point_z_i};

  // valid bits advance every cycle
  assign vld_d = {vld_q[6:1], start};

  // multiplier rows
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        prod1_d[c][t] = q_in[t] * p_in[TermB[c][t]];
        prod3_d[c][t] = qp2_q[t] * q2_q[TermB[c][t]];
        prod6_d[c][t] = diff5_q[t] * q5_q[TermB[c][t]];
      end
    end
  end

  // summing, saturating and subtract stages
  always_comb begin
    ovf2_d = 1'b0;
    ovf4_d = ovf3_q;
    ovf5_d = ovf4_q;
    ovf7_d = ovf6_q;
    for (int c = 0; c < 4; c++) begin
      s2[c]      = sum_shift_sat(prod1_q[c], TermNeg[c]);
      qp2_d[c]   = s2[c].value;
      ovf2_d     = ovf2_d | s2[c].ovf;
      s4[c]      = sum_shift_sat(prod3_q[c], ConjNeg[c]);
      rot4_d[c]  = s4[c].value;
      ovf4_d     = ovf4_d | s4[c].ovf;
      s5[c]      = sub_sat(p4_q[c], rot4_q[c]);
      diff5_d[c] = s5[c].value;
      ovf5_d     = ovf5_d | s5[c].ovf;
      s7[c]      = sum_shift_sat(prod6_q[c], TermNeg[c]);
      // halving: arithmetic shift right by one
      dual7_d[c] = {s7[c].value[31], s7[c].value[31:1]};
      ovf7_d     = ovf7_d | s7[c].ovf;
    end
  end

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload pipeline, no reset
  always_ff @(posedge clk_i) begin
    prod1_q <= prod1_d;
    q1_q    <= q_in;
    p1_q    <= p_in;

    qp2_q   <= qp2_d;
    ovf2_q  <= ovf2_d;
    q2_q    <= q1_q;
    p2_q    <= p1_q;

    prod3_q <= prod3_d;
    ovf3_q  <= ovf2_q;
    q3_q    <= q2_q;
    p3_q    <= p2_q;

    rot4_q  <= rot4_d;
    ovf4_q  <= ovf4_d;
    q4_q    <= q3_q;
    p4_q    <= p3_q;

    diff5_q <= diff5_d;
    ovf5_q  <= ovf5_d;
    q5_q    <= q4_q;

    prod6_q <= prod6_d;
    ovf6_q  <= ovf5_q;
    q6_q    <= q5_q;

    dual7_q <= dual7_d;
    ovf7_q  <= ovf7_d;
    q7_q    <= q6_q;
  end

  // result ports
  assign valid_o    = vld_q[7];
  assign real_w_o   = q7_q[0];
  assign real_x_o   = q7_q[1];
  assign real_y_o   = q7_q[2];
  assign real_z_o   = q7_q[3];
  assign dual_w_o   = dual7_q[0];
  assign dual_x_o   = dual7_q[1];
  assign dual_y_o   = dual7_q[2];
  assign dual_z_o   = dual7_q[3];
  assign overflow_o = ovf7_q;

`ifndef SYNTHESIS
  // every result comes from an item taken at the head of the valid pipeline
  a_valid_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, 7))
    else $error("result strobe without an item seven cycles earlier");

  // the real part is the rotation of that same item
  a_real_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (real_w_o == $past(rot_w_i, 7)) && (real_z_o == $past(rot_z_i, 7)))
    else $error("real part does not match the item's rotation");

  // the point rides alongside the first two products unchanged
  a_point_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> (p4_q[0] == $past(point_w_i, 4)) && (p4_q[3] == $past(point_z_i, 4)))
    else $error("point operand misaligned in the pipeline");
`endif

endmodule
